// ===== src/etr_pkg.sv =====
// ----------------------------------------------------------------------------
// etr_pkg
// shared types and codes of the execution trace recorder
// ----------------------------------------------------------------------------
package etr_pkg;

  localparam int unsigned ID_W     = 12;
  localparam int unsigned SLOT_W   = 15;
  localparam int unsigned MAX_SUCC = 255;

  typedef enum logic [1:0] {
    REQ_VALUE = 2'd0,
    REQ_FLAG  = 2'd1,
    REQ_EDGE  = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_NO_PREV  = 2'd0,
    ST_RECORDED = 2'd1,
    ST_PRESENT  = 2'd2,
    ST_NO_SLOT  = 2'd3
  } edge_status_e;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_READ,
    BK_EXEC,
    BK_WALK_RD,
    BK_WALK_CHK,
    BK_WRITE,
    BK_OUT
  } bk_state_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [11:0] entry_id;
    logic [63:0] sample_value;
    logic [14:0] slot_start;
    logic [7:0]  succ_count;
  } req_t;

  typedef struct packed {
    logic [63:0] min_seen;
    logic [63:0] max_seen;
    logic [63:0] flag_bits;
    logic [31:0] order_stamp;
    logic [31:0] event_count;
    logic [1:0]  edge_status;
  } rsp_t;

endpackage

// ===== src/etr_if.sv =====
// ----------------------------------------------------------------------------
// etr_req_if / etr_rsp_if
// valid/ready channels for events and results
// ----------------------------------------------------------------------------
interface etr_req_if;
  logic          valid;
  logic          ready;
  etr_pkg::req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface etr_rsp_if;
  logic          valid;
  logic          ready;
  etr_pkg::rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== src/etr_front.sv =====
// ----------------------------------------------------------------------------
// etr_front
// accepts events, clips the id and saturates the range, two-entry queue
// ----------------------------------------------------------------------------
module etr_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  etr_req_if.sink         req,
  output logic            q_valid_o,
  input  logic            q_pop_i,
  output etr_pkg::req_t   q_head_o
);
  etr_pkg::req_t buf_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    cnt_q;
  etr_pkg::req_t cls;
  logic          push;

  localparam int unsigned SATW = (etr_pkg::MAX_SUCC > 255) ? 255 : etr_pkg::MAX_SUCC;
  localparam logic [11:0] ID_MASK = 12'((1 << etr_pkg::ID_W) - 1);

  always_comb begin
    cls = req.payload;
    cls.entry_id = req.payload.entry_id & ID_MASK;
    if (req.payload.succ_count > 8'(SATW)) begin
      cls.succ_count = 8'(SATW);
    end
  end

  assign req.ready = (cnt_q != 2'd2);
  assign push      = req.valid && req.ready;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_head_o  = buf_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (q_pop_i) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count invalid");
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_i |-> q_valid_o) else $error("pop of empty queue");
  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !req.ready) else $error("ready while full");
endmodule

// ===== src/etr_back.sv =====
// ----------------------------------------------------------------------------
// etr_back
// read-modify-write of the trace tables and the successor slot walk
// ----------------------------------------------------------------------------
module etr_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  output logic          q_pop_o,
  input  etr_pkg::req_t q_head_i,
  etr_rsp_if.source     rsp,
  output logic          busy_o
);
  localparam int unsigned ID_W   = etr_pkg::ID_W;
  localparam int unsigned SLOT_W = etr_pkg::SLOT_W;
  localparam int unsigned IDS    = 1 << ID_W;
  localparam int unsigned SLOTS  = 1 << SLOT_W;
  localparam int unsigned CLR_W  = (SLOT_W > ID_W + 1) ? SLOT_W : ID_W + 1;

  // memories, zeroed by the clearing pass where the trace needs zero
  logic [63:0]       min_mem [IDS];
  logic [63:0]       max_mem [IDS];
  logic [63:0]       flag_mem [IDS];
  logic [31:0]       ord_mem [2*IDS];
  logic              vis_mem [2*IDS];
  logic [14:0]       bstart_mem [IDS];
  logic [7:0]        bcnt_mem [IDS];
  logic [11:0]       slot_mem [SLOTS];

  etr_pkg::bk_state_e st_q, st_d;
  etr_pkg::req_t      r_q;
  logic [CLR_W-1:0]   clr_q;
  logic [31:0]        cnt_q;
  logic [ID_W-1:0]    last_blk_q;
  logic [63:0]        mn_q, mx_q, fl_q;
  logic [31:0]        ord_q;
  logic               vis_rd_q;
  logic [14:0]        ps_q;
  logic [7:0]         pc_q;
  logic [SLOT_W:0]    pos_q;
  logic [8:0]         left_q;
  logic [11:0]        sl_q;
  logic [1:0]         status_q;
  etr_pkg::rsp_t      out_q;
  logic               out_v_q;

  logic [ID_W-1:0]    id;
  logic [ID_W:0]      oidx;
  logic               is_edge;
  logic [31:0]        cnt_n;
  logic               walk_end;
  logic               slot_hit;

  assign id       = r_q.entry_id[ID_W-1:0];
  assign is_edge  = (r_q.req_type == etr_pkg::REQ_EDGE);
  assign oidx     = {is_edge, id};
  assign cnt_n    = cnt_q + 32'd1;
  assign walk_end = (left_q == 9'd0) || (pos_q >= (SLOT_W+1)'(SLOTS));
  assign slot_hit = (sl_q == 12'd0) || (sl_q == 12'(id));

  always_comb begin
    st_d = st_q;
    case (st_q)
      etr_pkg::BK_CLEAR:    if (clr_q == '1) st_d = etr_pkg::BK_IDLE;
      etr_pkg::BK_IDLE:     if (q_valid_i && !out_v_q) st_d = etr_pkg::BK_READ;
      etr_pkg::BK_READ:     st_d = etr_pkg::BK_EXEC;
      etr_pkg::BK_EXEC: begin
        if (is_edge && last_blk_q != '0) st_d = etr_pkg::BK_WALK_RD;
        else st_d = etr_pkg::BK_WRITE;
      end
      etr_pkg::BK_WALK_RD: begin
        if (walk_end) st_d = etr_pkg::BK_WRITE;
        else st_d = etr_pkg::BK_WALK_CHK;
      end
      etr_pkg::BK_WALK_CHK: begin
        if (slot_hit) st_d = etr_pkg::BK_WRITE;
        else st_d = etr_pkg::BK_WALK_RD;
      end
      etr_pkg::BK_WRITE:    st_d = etr_pkg::BK_OUT;
      etr_pkg::BK_OUT:      st_d = etr_pkg::BK_IDLE;
      default:              st_d = etr_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop_o = (st_q == etr_pkg::BK_IDLE) && q_valid_i && !out_v_q;
    busy_o  = (st_q != etr_pkg::BK_IDLE);
  end

  assign rsp.valid   = out_v_q;
  assign rsp.payload = out_q;

  always_ff @(posedge clk_i) begin
    if (q_pop_o) r_q <= q_head_i;
    if (st_q == etr_pkg::BK_CLEAR) begin
      flag_mem[clr_q[ID_W-1:0]]   <= '0;
      ord_mem[clr_q[ID_W:0]]      <= '0;
      vis_mem[clr_q[ID_W:0]]      <= 1'b0;
      slot_mem[clr_q[SLOT_W-1:0]] <= '0;
    end
    if (st_q == etr_pkg::BK_READ) begin
      mn_q     <= min_mem[id];
      mx_q     <= max_mem[id];
      fl_q     <= flag_mem[id];
      ord_q    <= ord_mem[oidx];
      vis_rd_q <= vis_mem[oidx];
      ps_q     <= bstart_mem[last_blk_q];
      pc_q     <= bcnt_mem[last_blk_q];
    end
    if (st_q == etr_pkg::BK_EXEC) begin
      pos_q  <= (SLOT_W+1)'(ps_q);
      left_q <= 9'(pc_q);
    end
    if (st_q == etr_pkg::BK_WALK_RD) sl_q <= slot_mem[pos_q[SLOT_W-1:0]];
    if (st_q == etr_pkg::BK_WALK_CHK && !slot_hit) begin
      pos_q  <= pos_q + (SLOT_W+1)'(1);
      left_q <= left_q - 9'd1;
    end
    if (st_q == etr_pkg::BK_WRITE) begin
      case (r_q.req_type)
        etr_pkg::REQ_VALUE: begin
          min_mem[id] <= (vis_rd_q && mn_q <= r_q.sample_value) ? mn_q : r_q.sample_value;
          max_mem[id] <= (vis_rd_q && mx_q >= r_q.sample_value) ? mx_q : r_q.sample_value;
          vis_mem[oidx] <= 1'b1;
          if (ord_q == 32'd0) ord_mem[oidx] <= cnt_q;
        end
        etr_pkg::REQ_FLAG: flag_mem[id] <= fl_q | r_q.sample_value;
        etr_pkg::REQ_EDGE: begin
          vis_mem[oidx] <= 1'b1;
          if (ord_q == 32'd0) ord_mem[oidx] <= cnt_q;
          bstart_mem[id] <= r_q.slot_start;
          bcnt_mem[id]   <= r_q.succ_count;
          if (status_q == etr_pkg::ST_RECORDED) slot_mem[pos_q[SLOT_W-1:0]] <= 12'(id);
        end
        default: ;
      endcase
    end
    if (st_q == etr_pkg::BK_OUT) begin
      out_q <= '{
        min_seen:    (r_q.req_type == etr_pkg::REQ_VALUE) ? min_mem[id] : 64'd0,
        max_seen:    (r_q.req_type == etr_pkg::REQ_VALUE) ? max_mem[id] : 64'd0,
        flag_bits:   (r_q.req_type == etr_pkg::REQ_FLAG) ? flag_mem[id] : 64'd0,
        order_stamp: (r_q.req_type == etr_pkg::REQ_NONE) ? 32'd0 : ord_mem[oidx],
        event_count: cnt_q,
        edge_status: is_edge ? status_q : etr_pkg::ST_NO_PREV
      };
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= etr_pkg::BK_CLEAR;
      clr_q      <= '0;
      cnt_q      <= '0;
      last_blk_q <= '0;
      status_q   <= etr_pkg::ST_NO_PREV;
      out_v_q    <= 1'b0;
    end else begin
      st_q <= st_d;
      if (rsp.valid && rsp.ready) out_v_q <= 1'b0;
      case (st_q)
        etr_pkg::BK_CLEAR: clr_q <= clr_q + CLR_W'(1);
        etr_pkg::BK_READ: status_q <= etr_pkg::ST_NO_PREV;
        etr_pkg::BK_EXEC: begin
          if (r_q.req_type == etr_pkg::REQ_VALUE) cnt_q <= cnt_n;
        end
        etr_pkg::BK_WALK_RD: begin
          if (walk_end) status_q <= etr_pkg::ST_NO_SLOT;
        end
        etr_pkg::BK_WALK_CHK: begin
          if (sl_q == 12'd0) status_q <= etr_pkg::ST_RECORDED;
          else if (sl_q == 12'(id)) status_q <= etr_pkg::ST_PRESENT;
        end
        etr_pkg::BK_WRITE: begin
          if (is_edge) last_blk_q <= id;
        end
        etr_pkg::BK_OUT: out_v_q <= 1'b1;
        default: ;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == etr_pkg::BK_OUT |-> !out_v_q) else $error("result overwritten");
  a_walk_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == etr_pkg::BK_WALK_RD |-> is_edge) else $error("walk on non-edge");
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q != etr_pkg::BK_EXEC |=> cnt_q == $past(cnt_q)) else $error("counter slip");
endmodule

// ===== src/execution_trace_recorder.sv =====
// ----------------------------------------------------------------------------
// execution_trace_recorder
// per-site value/flag trace and basic-block successor recorder
// ----------------------------------------------------------------------------
// channel  dir  payload
// req      in   req_type entry_id sample_value slot_start succ_count
// rsp      out  min_seen max_seen flag_bits order_stamp event_count edge_status
//
// value, flag and unused events pass the back part through read, exec, write and out;
// edge events add a slot read and a check per compared slot, and one more read when
// the range or the table runs out; the slot walk sets the edge cost
// a two-entry queue lets events arrive while the back part works
// a waiting result holds the back part, which then fills the queue and stalls req
// after reset a clearing pass zeroes the flag, order, visited and successor
// stores before the first event starts
// ----------------------------------------------------------------------------
module execution_trace_recorder (
  input  logic      clk_i,
  input  logic      rst_ni,
  etr_req_if.sink   req,
  etr_rsp_if.source rsp
);
  logic          q_valid, q_pop, busy;
  etr_pkg::req_t q_head;

  etr_front u_front (
    .clk_i, .rst_ni, .req, .q_valid_o(q_valid), .q_pop_i(q_pop), .q_head_o(q_head)
  );

  etr_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_pop_o(q_pop), .q_head_i(q_head),
    .rsp, .busy_o(busy)
  );

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !busy) else $error("pop while busy");
  a_pop_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> busy) else $error("back part did not start");
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && !rsp.ready |=> rsp.valid) else $error("result dropped");
endmodule

// ===== tb/sv/etr_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// etr_tb_pkg
// trace predictor and result scoreboard for the execution trace recorder
// ----------------------------------------------------------------------------
package etr_tb_pkg;
  import etr_pkg::*;

  localparam int unsigned IDS = 4096;
  localparam int unsigned SLOTS = 32768;
  localparam int unsigned SUCC_CAP = 255;

  class trace_scoreboard;
    logic [63:0] site_min [IDS];
    logic [63:0] site_max [IDS];
    bit          seen [2*IDS];
    logic [31:0] stamp [2*IDS];
    logic [63:0] flags [IDS];
    logic [11:0] succ [SLOTS];
    logic [14:0] blk_start [IDS];
    logic [7:0]  blk_cnt [IDS];
    logic [31:0] value_cnt;
    logic [11:0] prev_block;
    rsp_t        pending_rsp [$];
    int          errors;
    int          checked;

    function void clear();
      foreach (seen[i]) begin
        seen[i] = 0;
        stamp[i] = '0;
      end
      foreach (flags[i]) begin
        flags[i] = '0;
        site_min[i] = '0;
        site_max[i] = '0;
        blk_start[i] = '0;
        blk_cnt[i] = '0;
      end
      foreach (succ[i]) succ[i] = '0;
      value_cnt = '0;
      prev_block = '0;
      pending_rsp.delete();
      errors = 0;
      checked = 0;
    endfunction

    function edge_status_e walk_successors(logic [11:0] blk);
      int unsigned pos;
      int unsigned left;
      pos = 32'(blk_start[prev_block]);
      left = 32'(blk_cnt[prev_block]);
      while (left > 0) begin
        if (pos >= SLOTS) return ST_NO_SLOT;
        if (succ[pos] == '0) begin
          succ[pos] = blk;
          return ST_RECORDED;
        end
        if (succ[pos] == blk) return ST_PRESENT;
        pos++;
        left--;
      end
      return ST_NO_SLOT;
    endfunction

    function void note_event(req_t r);
      rsp_t e;
      int unsigned id;
      int unsigned bi;
      e = '0;
      id = 32'(r.entry_id);
      bi = IDS + id;
      case (req_e'(r.req_type))
        REQ_VALUE: begin
          if (seen[id]) begin
            if (r.sample_value < site_min[id]) site_min[id] = r.sample_value;
            if (r.sample_value > site_max[id]) site_max[id] = r.sample_value;
          end else begin
            site_min[id] = r.sample_value;
            site_max[id] = r.sample_value;
            seen[id] = 1;
          end
          value_cnt = value_cnt + 1;
          if (stamp[id] == '0) stamp[id] = value_cnt;
          e.min_seen = site_min[id];
          e.max_seen = site_max[id];
          e.order_stamp = stamp[id];
        end
        REQ_FLAG: begin
          flags[id] |= r.sample_value;
          e.flag_bits = flags[id];
          e.order_stamp = stamp[id];
        end
        REQ_EDGE: begin
          e.edge_status = ST_NO_PREV;
          if (prev_block != '0) e.edge_status = walk_successors(r.entry_id);
          seen[bi] = 1;
          if (stamp[bi] == '0) stamp[bi] = value_cnt;
          blk_start[id] = r.slot_start;
          blk_cnt[id] = (r.succ_count > SUCC_CAP) ? 8'(SUCC_CAP) : r.succ_count;
          prev_block = r.entry_id;
          e.order_stamp = stamp[bi];
        end
        default: ;
      endcase
      e.event_count = value_cnt;
      pending_rsp.push_back(e);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] exp);
      errors++;
      $display("mismatch %s: got %h expected %h", what, got, exp);
    endtask

    task check_result(rsp_t got);
      rsp_t e;
      if (pending_rsp.size() == 0) begin
        report("unexpected result", 64'(got.event_count), '0);
        return;
      end
      e = pending_rsp.pop_front();
      checked++;
      if (got.min_seen !== e.min_seen) report("min_seen", got.min_seen, e.min_seen);
      if (got.max_seen !== e.max_seen) report("max_seen", got.max_seen, e.max_seen);
      if (got.flag_bits !== e.flag_bits) report("flag_bits", got.flag_bits, e.flag_bits);
      if (got.order_stamp !== e.order_stamp)
        report("order_stamp", 64'(got.order_stamp), 64'(e.order_stamp));
      if (got.event_count !== e.event_count)
        report("event_count", 64'(got.event_count), 64'(e.event_count));
      if (got.edge_status !== e.edge_status)
        report("edge_status", 64'(got.edge_status), 64'(e.edge_status));
    endtask
  endclass

endpackage

// ===== tb/sv/execution_trace_recorder_tb.sv =====
// ----------------------------------------------------------------------------
// execution_trace_recorder_tb
// drives value, flag and edge events with random gaps and back-pressure and
// checks every result against a predictor of the trace tables
// ----------------------------------------------------------------------------
module execution_trace_recorder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import etr_pkg::*;
  import etr_tb_pkg::*;

  logic clk_i;
  logic rst_ni;
  bit   hold_rsp;
  bit   src_done;
  int   n_value, n_flag, n_edge, n_none;

  etr_req_if req_ch ();
  etr_rsp_if rsp_ch ();
  trace_scoreboard sb;

  execution_trace_recorder u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req   (req_ch.sink),
    .rsp   (rsp_ch.source)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  task automatic send_event(req_t r);
    req_ch.valid <= 1'b1;
    req_ch.payload <= r;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    sb.note_event(r);
    case (req_e'(r.req_type))
      REQ_VALUE: n_value++;
      REQ_FLAG: n_flag++;
      REQ_EDGE: n_edge++;
      default: n_none++;
    endcase
  endtask

  task automatic send_gapped(req_t r, bit burst);
    int g;
    send_event(r);
    g = burst ? 0 : gap_len();
    if (g > 0) begin
      req_ch.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  function automatic req_t make_event(req_e k, logic [11:0] id, logic [63:0] v,
                                      logic [14:0] s, logic [7:0] c);
    req_t r;
    r.req_type = k;
    r.entry_id = id;
    r.sample_value = v;
    r.slot_start = s;
    r.succ_count = c;
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic req_t random_event(bit [11:0] site_base, bit [11:0] blk_base);
    req_t r;
    int p;
    p = $urandom_range(99);
    r = make_event(REQ_VALUE, 12'(site_base + $urandom_range(15)), rand64(),
                   15'($urandom()), 8'($urandom()));
    if ($urandom_range(3) == 0) r.sample_value = 64'($urandom_range(20));
    if ($urandom_range(9) == 0) r.entry_id = 12'($urandom());
    if (p < 40) r.req_type = REQ_VALUE;
    else if (p < 55) r.req_type = REQ_FLAG;
    else if (p < 95) begin
      r.req_type = REQ_EDGE;
      r.entry_id = ($urandom_range(19) == 0) ? 12'd0 : 12'(blk_base + $urandom_range(11));
      r.succ_count = ($urandom_range(9) == 0) ? 8'($urandom()) : 8'($urandom_range(4));
      if ($urandom_range(19) == 0) r.slot_start = 15'h7fff - 15'($urandom_range(2));
      else r.slot_start = 15'($urandom_range(2000));
    end else r.req_type = REQ_NONE;
    return r;
  endfunction

  task automatic drain_wait();
    int guard;
    guard = 0;
    req_ch.valid <= 1'b0;
    while (sb.pending_rsp.size() != 0 && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
  endtask

  // result side: random stalls, or a long hold-off when asked
  initial begin
    rsp_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      int g;
      if (hold_rsp) begin
        rsp_ch.ready <= 1'b0;
        @(posedge clk_i);
      end else begin
        g = gap_len();
        rsp_ch.ready <= (g == 0);
        @(posedge clk_i);
        if (rsp_ch.valid && rsp_ch.ready) sb.check_result(rsp_ch.payload);
        repeat (g > 0 ? g - 1 : 0) @(posedge clk_i);
      end
    end
  end

  initial begin
    req_t r;
    sb = new();
    sb.clear();
    rst_ni = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.payload = '0;
    hold_rsp = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, every event kind, block zero, table end, long range
    send_gapped(make_event(REQ_EDGE, 12'd5, '0, 15'd100, 8'd2), 0);
    send_gapped(make_event(REQ_VALUE, 12'd0, '0, '0, '0), 0);
    send_gapped(make_event(REQ_VALUE, 12'd0, '1, '1, '1), 0);
    send_gapped(make_event(REQ_VALUE, 12'hfff, 64'h8000_0000_0000_0000, '0, '0), 0);
    send_gapped(make_event(REQ_VALUE, 12'hfff, 64'h1, '0, '0), 0);
    send_gapped(make_event(REQ_FLAG, 12'hfff, 64'h5555_5555_5555_5555, '0, '0), 0);
    send_gapped(make_event(REQ_FLAG, 12'hfff, 64'haaaa_aaaa_aaaa_aaaa, '0, '0), 0);
    send_gapped(make_event(REQ_FLAG, 12'd7, '0, '0, '0), 0);
    send_gapped(make_event(REQ_EDGE, 12'd9, '0, 15'd102, 8'd1), 0);
    send_gapped(make_event(REQ_EDGE, 12'd5, '0, 15'd100, 8'd2), 0);
    send_gapped(make_event(REQ_EDGE, 12'd9, '0, 15'd102, 8'd1), 0);
    send_gapped(make_event(REQ_EDGE, 12'd5, '0, 15'd100, 8'd2), 0);
    send_gapped(make_event(REQ_EDGE, 12'd6, '0, 15'h7ffe, 8'hff), 0);
    send_gapped(make_event(REQ_EDGE, 12'd5, '0, 15'd100, 8'd2), 0);
    send_gapped(make_event(REQ_EDGE, 12'd11, '0, 15'h7ffe, 8'd0), 0);
    send_gapped(make_event(REQ_EDGE, 12'd0, '0, 15'd0, 8'd3), 0);
    send_gapped(make_event(REQ_EDGE, 12'd0, '0, '1, '1), 0);
    send_gapped(make_event(REQ_EDGE, 12'hfff, '0, 15'd200, 8'd0), 0);
    send_gapped(make_event(REQ_NONE, 12'hfff, '1, '1, '1), 0);
    send_gapped(make_event(REQ_VALUE, 12'd3, 64'd7, '0, '0), 0);

    // pause until all results are in
    drain_wait();

    // long receiver hold-off while events keep coming
    fork
      begin
        hold_rsp = 1;
        repeat (300) @(posedge clk_i);
        hold_rsp = 0;
      end
      for (int i = 0; i < 30; i++) send_gapped(random_event(12'd0, 12'd1), 1);
    join

    for (int i = 0; i < 1800; i++) begin
      r = random_event(12'(($urandom_range(3)) * 16), 12'd1 + 12'($urandom_range(1) * 12));
      send_gapped(r, (i / 150) % 2 == 1);
    end
    req_ch.valid <= 1'b0;
    drain_wait();
    repeat (200) @(posedge clk_i);

    $display("covered %0d value, %0d flag, %0d edge and %0d unused events, %0d results",
             n_value, n_flag, n_edge, n_none, sb.checked);
    if (sb.errors == 0 && sb.pending_rsp.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.pending_rsp.size());
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end

endmodule
